@@ sv/gpio_pin_register_controller_defines.svh @@
// Assertion macros used by the back end of the controller.
`ifndef GPIO_PIN_REGISTER_CONTROLLER_DEFINES_SVH
`define GPIO_PIN_REGISTER_CONTROLLER_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define GPR_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define GPR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gpr_pkg.sv @@
`timescale 1ns / 1ps

package gpr_pkg;

  // Store geometry: ten port slots of WORDS_PER_PORT words each.
  localparam int WORDS_PER_PORT = 9;
  localparam int SLOT_COUNT     = 10;
  localparam int STORE_DEPTH    = SLOT_COUNT * WORDS_PER_PORT;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int WORD_W         = 32;

  // Pin numbering.
  localparam int PIN_COUNT = 93;
  localparam int PIN_W     = 7;
  localparam int IDX_W     = 5;

  // First pin of each port.
  localparam logic [PIN_W-1:0] FIRST_D = 7'd17;
  localparam logic [PIN_W-1:0] FIRST_F = 7'd44;
  localparam logic [PIN_W-1:0] FIRST_G = 7'd51;
  localparam logic [PIN_W-1:0] FIRST_H = 7'd66;
  localparam logic [PIN_W-1:0] FIRST_L = 7'd77;
  localparam logic [PIN_W-1:0] FIRST_M = 7'd88;

  // Slot numbers of the ports.
  localparam logic [3:0] SLOT_C = 4'd2;
  localparam logic [3:0] SLOT_D = 4'd3;
  localparam logic [3:0] SLOT_F = 4'd5;
  localparam logic [3:0] SLOT_G = 4'd6;
  localparam logic [3:0] SLOT_H = 4'd7;
  localparam logic [3:0] SLOT_L = 4'd8;
  localparam logic [3:0] SLOT_M = 4'd9;

  // Word offsets within a slot.
  localparam logic [3:0] OFS_DATA = 4'd4;
  localparam logic [3:0] OFS_PULL = 4'd7;

  // Command codes.
  localparam logic [2:0] CMD_READ_LEVEL = 3'd0;
  localparam logic [2:0] CMD_READ_MODE  = 3'd1;
  localparam logic [2:0] CMD_SET_DIR    = 3'd2;
  localparam logic [2:0] CMD_SET_LEVEL  = 3'd3;
  localparam logic [2:0] CMD_SET_PULL   = 3'd4;

  // Mode field value that marks an output.
  localparam logic [2:0] MODE_OUTPUT = 3'd1;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified command waiting for the back.
  typedef struct packed {
    logic [2:0]        cmd;
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  idx;
    logic [1:0]        val;
  } entry_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

@@ sv/gpr_front.sv @@
`timescale 1ns / 1ps

module gpr_front (
  input  logic [2:0]                 command,
  input  logic [gpr_pkg::PIN_W-1:0] pin,
  input  logic [1:0]                 value,
  output gpr_pkg::entry_t            entry
);
  import gpr_pkg::*;

  logic [3:0]       slot;
  logic [PIN_W-1:0] base;
  logic [PIN_W-1:0] rel;
  logic [IDX_W-1:0] idx;
  logic [3:0]       offset;
  logic             ok;

  // Map the flat pin number onto a port slot and the first pin of that port.
  always_comb begin
    if (pin < FIRST_D) begin
      slot = SLOT_C;
      base = '0;
    end else if (pin < FIRST_F) begin
      slot = SLOT_D;
      base = FIRST_D;
    end else if (pin < FIRST_G) begin
      slot = SLOT_F;
      base = FIRST_F;
    end else if (pin < FIRST_H) begin
      slot = SLOT_G;
      base = FIRST_G;
    end else if (pin < FIRST_L) begin
      slot = SLOT_H;
      base = FIRST_H;
    end else if (pin < FIRST_M) begin
      slot = SLOT_L;
      base = FIRST_L;
    end else begin
      slot = SLOT_M;
      base = FIRST_M;
    end
  end

  assign rel = pin - base;
  assign idx = rel[IDX_W-1:0];
  assign ok  = (pin < PIN_W'(PIN_COUNT));

  // Pick the word of the slot that the command touches.
  always_comb begin
    case (command)
      CMD_READ_LEVEL: offset = OFS_DATA;
      CMD_SET_LEVEL:  offset = OFS_DATA;
      CMD_READ_MODE:  offset = {2'b00, idx[4:3]};
      CMD_SET_DIR:    offset = {2'b00, idx[4:3]};
      CMD_SET_PULL:   offset = OFS_PULL + {3'b000, idx[4]};
      default:        offset = '0;
    endcase
  end

  // Build the queue entry; a refused pin carries address zero and no effect.
  always_comb begin
    entry.cmd  = command;
    entry.ok   = ok;
    entry.idx  = idx;
    entry.val  = value;
    entry.addr = ok ? (ADDR_W'(slot) * ADDR_W'(WORDS_PER_PORT) + ADDR_W'(offset)) : '0;
  end

endmodule

@@ sv/gpr_queue.sv @@
`timescale 1ns / 1ps

module gpr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gpr_pkg::entry_t     push_entry,
  input  logic                pop,
  output gpr_pkg::entry_t     head,
  output gpr_pkg::q_status_t  status
);
  import gpr_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head         = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ sv/gpr_back.sv @@
`timescale 1ns / 1ps
`include "gpio_pin_register_controller_defines.svh"

module gpr_back (
  input  logic               clk,
  input  logic               rst,
  input  gpr_pkg::entry_t    head,
  input  gpr_pkg::q_status_t status,
  output logic               pop,
  output logic               done,
  output logic               accepted,
  output logic               pin_high,
  output logic [2:0]         pin_mode,
  output logic               pin_is_output
);
  import gpr_pkg::*;

  localparam logic [0:0] ST_FETCH = 1'b0;
  localparam logic [0:0] ST_EXEC  = 1'b1;

  logic [0:0]             state;
  entry_t                 cur;
  logic [WORD_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] word_valid;
  logic [WORD_W-1:0]      rd_data;
  logic                   rd_valid;
  logic [WORD_W-1:0]      old_word;
  logic [WORD_W-1:0]      new_word;
  logic                   wr_en;
  logic [4:0]             sh_mode;
  logic [4:0]             sh_pull;
  logic [2:0]             mode_field;
  logic                   bit_val;

  // Take an entry only when no read-modify-write is in flight.
  assign pop  = (state == ST_FETCH) && !status.empty;
  assign done = (state == ST_EXEC);

  // Sequencer: a fetch state then an execute state per command.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FETCH;
    end else begin
      case (state)
        ST_FETCH: if (pop) state <= ST_EXEC;
        ST_EXEC:  state <= ST_FETCH;
        default:  state <= ST_FETCH;
      endcase
    end
  end

  // Per-word valid flags; an unwritten word reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (pop) begin
        rd_valid <= word_valid[head.addr];
      end
      if (wr_en) begin
        word_valid[cur.addr] <= 1'b1;
      end
    end
  end

  // Word store with a registered read port and one write port.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= head;
      rd_data <= mem[head.addr];
    end
    if (wr_en) begin
      mem[cur.addr] <= new_word;
    end
  end

  assign old_word   = rd_valid ? rd_data : '0;
  assign sh_mode    = {cur.idx[2:0], 2'b00};
  assign sh_pull    = {cur.idx[3:0], 1'b0};
  assign mode_field = 3'(old_word >> sh_mode);
  assign bit_val    = (cur.val != 2'b00);

  // Modify the fetched word according to the command.
  always_comb begin
    new_word = old_word;
    wr_en    = 1'b0;
    case (cur.cmd)
      CMD_SET_DIR: begin
        new_word = (old_word & ~(WORD_W'(3'b111) << sh_mode)) |
                   (WORD_W'(bit_val) << sh_mode);
        wr_en    = done && cur.ok;
      end
      CMD_SET_LEVEL: begin
        new_word = (old_word & ~(WORD_W'(1'b1) << cur.idx)) |
                   (WORD_W'(bit_val) << cur.idx);
        wr_en    = done && cur.ok;
      end
      CMD_SET_PULL: begin
        new_word = (old_word & ~(WORD_W'(2'b11) << sh_pull)) |
                   (WORD_W'(cur.val) << sh_pull);
        wr_en    = done && cur.ok;
      end
      default: begin
        new_word = old_word;
        wr_en    = 1'b0;
      end
    endcase
  end

  // Result fields, meaningful while done is high.
  assign accepted      = cur.ok;
  assign pin_high      = cur.ok && (cur.cmd == CMD_READ_LEVEL) && old_word[cur.idx];
  assign pin_mode      = (cur.ok && (cur.cmd == CMD_READ_MODE)) ? mode_field : '0;
  assign pin_is_output = cur.ok && (cur.cmd == CMD_READ_MODE) &&
                         (mode_field == MODE_OUTPUT);

  `GPR_ASSERT_NEXT(a_pop_then_done, clk, rst, pop, done, "fetched entry not executed")
  `GPR_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe longer than one cycle")
  `GPR_ASSERT_SAME(a_refused_quiet, clk, rst, done && !accepted,
    !pin_high && (pin_mode == 3'b000) && !pin_is_output && !wr_en,
    "refused pin produced data or a write")

endmodule

@@ sv/gpio_pin_register_controller.sv @@
`timescale 1ns / 1ps
// A transferred command waits in the queue until the back end fetches it; done high marks its result.
// The back end takes no new command until the fetch and write-back of the word store for the last one are through.
// Two further commands are held in a queue; busy is high while the queue is full.
// Reset (rst, synchronous) empties the queue and marks every store word as zero at once.
// The receiver cannot stall: each result appears for exactly one cycle.

module gpio_pin_register_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command,
  input  logic [6:0] pin,
  input  logic [1:0] value,
  output logic       done,
  output logic       accepted,
  output logic       pin_high,
  output logic [2:0] pin_mode,
  output logic       pin_is_output
);
  import gpr_pkg::*;

  entry_t    front_entry;
  entry_t    head;
  q_status_t status;
  logic      push;
  logic      pop;

  // A command transfers when start is high and the queue has room.
  assign busy = status.full;
  assign push = start && !status.full;

  // Decode of pin and command.
  gpr_front u_front (
    .command (command),
    .pin     (pin),
    .value   (value),
    .entry   (front_entry)
  );

  // Queue between decode and execution.
  gpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  // Read-modify-write of the word store.
  gpr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .status        (status),
    .pop           (pop),
    .done          (done),
    .accepted      (accepted),
    .pin_high      (pin_high),
    .pin_mode      (pin_mode),
    .pin_is_output (pin_is_output)
  );

endmodule
